/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Implication that must hold at every clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/kfpv_pkg.sv */
`default_nettype none
package kfpv_pkg;
  localparam int unsigned FracBits = 16;
  localparam int unsigned ValueWidth = 48;
  localparam int unsigned ProdWidth = 2 * ValueWidth;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned CfgDataWidth = 32;
  localparam int unsigned DistWidth = 13;
  localparam int unsigned DriveWidth = 9;

  typedef logic signed [ValueWidth-1:0] value_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgTransPosVel = 3'd0,
    CfgTransVelVel = 3'd1,
    CfgInputGain   = 3'd2,
    CfgProcNoise   = 3'd3,
    CfgMeasNoise   = 3'd4
  } cfg_idx_e;

  localparam value_t ValMax = {1'b0, {(ValueWidth-1){1'b1}}};
  localparam value_t ValMin = {1'b1, {(ValueWidth-1){1'b0}}};

  // Saturating sum of two values.
  function automatic value_t sat_add(value_t a, value_t b);
    logic signed [ValueWidth:0] s;
    s = {a[ValueWidth-1], a} + {b[ValueWidth-1], b};
    if (s[ValueWidth] != s[ValueWidth-1]) begin
      sat_add = s[ValueWidth] ? ValMin : ValMax;
    end else begin
      sat_add = s[ValueWidth-1:0];
    end
  endfunction

  // Saturates a wide signed value down to the value width.
  function automatic value_t sat_wide(logic signed [ProdWidth:0] v);
    if (v > $signed({{(ProdWidth-ValueWidth+1){1'b0}}, ValMax})) begin
      sat_wide = ValMax;
    end else if (v < $signed({{(ProdWidth-ValueWidth+1){1'b1}}, ValMin})) begin
      sat_wide = ValMin;
    end else begin
      sat_wide = v[ValueWidth-1:0];
    end
  endfunction
endpackage
`default_nettype wire

/* hw/rtl/kfpv_if.sv */
`default_nettype none
interface kfpv_in_if;
  logic valid;
  logic ready;
  logic [12:0] distance;
  logic signed [8:0] drive;
  modport source (output valid, distance, drive, input ready);
  modport sink (input valid, distance, drive, output ready);
endinterface

interface kfpv_out_if;
  logic valid;
  logic ready;
  logic signed [47:0] position_est;
  logic signed [47:0] velocity_est;
  modport source (output valid, position_est, velocity_est, input ready);
  modport sink (input valid, position_est, velocity_est, output ready);
endinterface

interface kfpv_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/kfpv_mul.sv */
`default_nettype none
// Sequential signed multiplier: magnitude product of 24x24 partial products,
// one per cycle, optionally shifted, truncated toward zero and saturated.
module kfpv_mul import kfpv_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   start_i,
  input  wire value_t a_i,
  input  wire value_t b_i,
  input  wire logic   shift_i,
  output      logic   done_o,
  output      value_t res_o
);
  localparam int unsigned HalfW = ValueWidth / 2;

  logic [ValueWidth-1:0] ma_q, mb_q;
  logic                  neg_q, sh_q, busy_q;
  logic [2:0]            step_q;
  logic [ProdWidth-1:0]  acc_q;
  logic [HalfW-1:0]      pa, pb;
  logic [ProdWidth-1:0]  part;
  logic [ProdWidth-1:0]  mag_sh;
  logic [ProdWidth:0]    res_w;

  // Pick the partial product operands for this step.
  always_comb begin
    pa = step_q[1] ? ma_q[ValueWidth-1:HalfW] : ma_q[HalfW-1:0];
    pb = step_q[0] ? mb_q[ValueWidth-1:HalfW] : mb_q[HalfW-1:0];
    part = ProdWidth'(pa * pb) << (HalfW * (32'(step_q[1]) + 32'(step_q[0])));
  end

  // Final shift, sign and saturation.
  always_comb begin
    mag_sh = sh_q ? (acc_q >> FracBits) : acc_q;
    res_w = neg_q ? -$signed({1'b0, mag_sh}) : $signed({1'b0, mag_sh});
    res_o = sat_wide(res_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 3'd1;
        if (step_q == 3'd3) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q  <= a_i[ValueWidth-1] ? ValueWidth'(-a_i) : a_i;
      mb_q  <= b_i[ValueWidth-1] ? ValueWidth'(-b_i) : b_i;
      neg_q <= a_i[ValueWidth-1] ^ b_i[ValueWidth-1];
      sh_q  <= shift_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + part;
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/kfpv_div.sv */
`default_nettype none
// Restoring divider: one quotient bit per cycle over the numerator magnitude
// shifted up by the fraction bits, then signed and saturated.
module kfpv_div import kfpv_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   start_i,
  input  wire value_t num_i,
  input  wire value_t den_i,
  output      logic   done_o,
  output      value_t res_o
);
  localparam int unsigned NumW = ValueWidth + FracBits;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0]     n_q, q_q;
  logic [ValueWidth:0] rem_q, d_q;
  logic                neg_q, busy_q;
  logic [CntW-1:0]     cnt_q;
  logic [ValueWidth:0] trial;
  logic [ProdWidth:0]  res_w;

  assign trial = {rem_q[ValueWidth-1:0], n_q[NumW-1]};

  always_comb begin
    res_w = neg_q ? -$signed((ProdWidth+1)'(q_q)) : $signed((ProdWidth+1)'(q_q));
    res_o = sat_wide(res_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= {(num_i[ValueWidth-1] ? ValueWidth'(-num_i) : num_i), {FracBits{1'b0}}};
      d_q   <= {1'b0, (den_i[ValueWidth-1] ? ValueWidth'(-den_i) : den_i)};
      neg_q <= num_i[ValueWidth-1] ^ den_i[ValueWidth-1];
      rem_q <= '0;
      q_q   <= '0;
    end else if (busy_q) begin
      n_q <= n_q << 1;
      if (trial >= d_q) begin
        rem_q <= trial - d_q;
        q_q   <= {q_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        q_q   <= {q_q[NumW-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/kalman_filter_pos_vel.sv */
`default_nettype none
// Two-state position/velocity Kalman filter in signed Q31.16 with saturation.
// One transaction on the input channel runs a full predict and correct step
// through one shared sequential multiplier and one bit-serial divider. There
// are 17 products and two divisions, plus closing steps to finish. A zero
// innovation variance skips the divisions. The input is not ready while an
// item is in progress. The result waits in an output register. The next
// item may be taken while it waits, but that item's result is held back
// until the register is free. Configuration writes are always accepted and
// should only be done when idle.
`include "assert_macros.svh"
module kalman_filter_pos_vel import kfpv_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  kfpv_cfg_if.sink cfg,
  kfpv_in_if.sink  in_ch,
  kfpv_out_if.source out_ch
);
  // Sequencer step codes.
  localparam logic [5:0] StIdle = 6'd0;
  localparam logic [5:0] StLast = 6'd25;

  logic [19:0] cfg_a_q;
  logic [16:0] cfg_b_q;
  logic signed [24:0] cfg_g_q;
  logic [31:0] cfg_q_q, cfg_r_q;

  value_t pos_q, vel_q, c00_q, c01_q, c10_q, c11_q;
  value_t xp0_q, xp1_q, m00_q, m01_q, m10_q, m11_q;
  value_t p00_q, p01_q, p10_q, p11_q, ym_q, sm_q, k0_q, k1_q, dist_q;
  logic signed [DriveWidth-1:0] drv_q;

  logic [5:0] st_q;
  logic       wait_q;
  logic       out_valid_q;
  value_t     out_pos_q, out_vel_q;

  logic   mul_start, mul_done, mul_sh;
  value_t mul_a, mul_b, mul_r;
  logic   div_start, div_done;
  value_t div_n, div_r;

  value_t va, vb, vg, vq, vr;
  assign va = value_t'(cfg_a_q);
  assign vb = value_t'(cfg_b_q);
  assign vg = value_t'(cfg_g_q);
  assign vq = value_t'(cfg_q_q);
  assign vr = value_t'(cfg_r_q);

  assign cfg.ready = 1'b1;
  assign in_ch.ready = (st_q == StIdle);
  assign out_ch.valid = out_valid_q;
  assign out_ch.position_est = out_pos_q;
  assign out_ch.velocity_est = out_vel_q;

  // Operand selection for each multiply step.
  always_comb begin
    mul_a = va;
    mul_b = vel_q;
    mul_sh = 1'b1;
    div_n = p00_q;
    unique case (st_q)
      6'd1: begin mul_a = va; mul_b = vel_q; end
      6'd2: begin mul_a = vb; mul_b = vel_q; end
      6'd3: begin mul_a = vg; mul_b = value_t'(drv_q); mul_sh = 1'b0; end
      6'd4: begin mul_a = va; mul_b = c10_q; end
      6'd5: begin mul_a = va; mul_b = c11_q; end
      6'd6: begin mul_a = vb; mul_b = c10_q; end
      6'd7: begin mul_a = vb; mul_b = c11_q; end
      6'd8: begin mul_a = va; mul_b = m01_q; end
      6'd9: begin mul_a = m01_q; mul_b = vb; end
      6'd10: begin mul_a = va; mul_b = m11_q; end
      6'd11: begin mul_a = m11_q; mul_b = vb; end
      6'd12: div_n = p00_q;
      6'd13: div_n = p10_q;
      6'd14: begin mul_a = k0_q; mul_b = ym_q; end
      6'd15: begin mul_a = k1_q; mul_b = ym_q; end
      6'd16: begin mul_a = k0_q; mul_b = p00_q; end
      6'd17: begin mul_a = k0_q; mul_b = p01_q; end
      6'd18: begin mul_a = k1_q; mul_b = p00_q; end
      6'd19: begin mul_a = k1_q; mul_b = p01_q; end
      default: ;
    endcase
  end

  logic is_div_st, is_mul_st, zero_s;
  assign is_div_st = (st_q == 6'd12) || (st_q == 6'd13);
  assign is_mul_st = (st_q >= 6'd1) && (st_q <= 6'd19) && !is_div_st;
  assign zero_s = (sm_q == '0);
  assign mul_start = is_mul_st && !wait_q;
  assign div_start = is_div_st && !wait_q && !zero_s;

  kfpv_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .shift_i(mul_sh), .done_o(mul_done), .res_o(mul_r)
  );

  kfpv_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_n), .den_i(sm_q),
    .done_o(div_done), .res_o(div_r)
  );

  logic step_done;
  assign step_done = is_div_st ? (zero_s || div_done) : mul_done;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_a_q <= 20'd6095;
      cfg_b_q <= 17'd64498;
      cfg_g_q <= 25'sd1869585;
      cfg_q_q <= 32'd70463265;
      cfg_r_q <= 32'd1638400;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CfgTransPosVel: cfg_a_q <= cfg.data[19:0];
        CfgTransVelVel: cfg_b_q <= cfg.data[16:0];
        CfgInputGain:   cfg_g_q <= cfg.data[24:0];
        CfgProcNoise:   cfg_q_q <= cfg.data;
        CfgMeasNoise:   cfg_r_q <= cfg.data;
        default: ;
      endcase
    end
  end

  // Sequencer and filter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      wait_q <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q <= -value_t'(2000) <<< FracBits;
      vel_q <= '0;
      c00_q <= value_t'(25) <<< FracBits;
      c01_q <= '0;
      c10_q <= '0;
      c11_q <= value_t'(25) <<< FracBits;
    end else begin
      if (out_ch.valid && out_ch.ready && (st_q != StLast)) out_valid_q <= 1'b0;
      if (st_q == StIdle) begin
        if (in_ch.valid && in_ch.ready) begin
          st_q <= 6'd1;
          dist_q <= value_t'({in_ch.distance, {FracBits{1'b0}}});
          drv_q <= in_ch.drive;
        end
      end else if (st_q == StLast) begin
        // Hand over the result once the output register is free.
        if (!out_valid_q || out_ch.ready) begin
          out_pos_q <= pos_q;
          out_vel_q <= vel_q;
          out_valid_q <= 1'b1;
          st_q <= StIdle;
        end
      end else if (st_q >= 6'd20) begin
        st_q <= st_q + 6'd1;
      end else begin
        if (!wait_q) wait_q <= 1'b1;
        if (wait_q && step_done) begin
          wait_q <= 1'b0;
          st_q <= st_q + 6'd1;
          unique case (st_q)
            6'd1: xp0_q <= sat_add(pos_q, mul_r);
            6'd2: xp1_q <= mul_r;
            6'd3: begin
              xp1_q <= sat_add(xp1_q, mul_r);
              ym_q <= sat_add(dist_q, xp0_q);
            end
            6'd4: m00_q <= sat_add(c00_q, mul_r);
            6'd5: m01_q <= sat_add(c01_q, mul_r);
            6'd6: m10_q <= mul_r;
            6'd7: m11_q <= mul_r;
            6'd8: p00_q <= sat_add(sat_add(m00_q, mul_r), vq);
            6'd9: p01_q <= mul_r;
            6'd10: p10_q <= sat_add(m10_q, mul_r);
            6'd11: begin
              p11_q <= sat_add(mul_r, vq);
              sm_q <= sat_add(p00_q, vr);
            end
            6'd12: k0_q <= zero_s ? '0 : sat_wide(-$signed((ProdWidth+1)'(div_r)));
            6'd13: k1_q <= zero_s ? '0 : sat_wide(-$signed((ProdWidth+1)'(div_r)));
            6'd14: pos_q <= sat_add(xp0_q, mul_r);
            6'd15: vel_q <= sat_add(xp1_q, mul_r);
            6'd16: c00_q <= sat_add(p00_q, mul_r);
            6'd17: c01_q <= sat_add(p01_q, mul_r);
            6'd18: c10_q <= sat_add(mul_r, p10_q);
            6'd19: c11_q <= sat_add(mul_r, p11_q);
            default: ;
          endcase
        end
      end
    end
  end

  `ASSERT_IMPLIES(a_busy_not_ready, clk_i, rst_ni, st_q != StIdle, !in_ch.ready)
  `ASSERT_IMPLIES(a_one_unit, clk_i, rst_ni, mul_start, !div_start)
  `ASSERT_IMPLIES(a_result_held, clk_i, rst_ni, out_valid_q && !out_ch.ready,
                  ##1 out_valid_q && $stable(out_pos_q))
endmodule
`default_nettype wire
